>>> rtl/core/crc_frx_pkg.sv
package crc_frx_pkg;

  localparam int unsigned HeaderBytes = 24;
  localparam int unsigned PosWidth = 5;

  localparam logic [31:0] CrcPoly = 32'hEDB88320;
  localparam logic [31:0] CrcOnes = 32'hFFFFFFFF;

  localparam logic [15:0] MaxLenReset = 16'd1024;

  localparam logic [1:0] PHASE_HEADER  = 2'd0;
  localparam logic [1:0] PHASE_PAYLOAD = 2'd1;
  localparam logic [1:0] PHASE_HALTED  = 2'd2;

  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_CRC_BAD  = 2'd1;
  localparam logic [1:0] STATUS_TOO_LONG = 2'd2;

  localparam logic [PosWidth-1:0] POS_TYPE      = PosWidth'(1);
  localparam logic [PosWidth-1:0] POS_FLAGS     = PosWidth'(2);
  localparam logic [PosWidth-1:0] POS_LEN_HI    = PosWidth'(4);
  localparam logic [PosWidth-1:0] POS_LEN_LO    = PosWidth'(5);
  localparam logic [PosWidth-1:0] POS_ID_FIRST  = PosWidth'(8);
  localparam logic [PosWidth-1:0] POS_ID_LAST   = PosWidth'(11);
  localparam logic [PosWidth-1:0] POS_TS_FIRST  = PosWidth'(12);
  localparam logic [PosWidth-1:0] POS_TS_LAST   = PosWidth'(15);
  localparam logic [PosWidth-1:0] POS_CRC_FIRST = PosWidth'(16);
  localparam logic [PosWidth-1:0] POS_CRC_LAST  = PosWidth'(19);
  localparam logic [PosWidth-1:0] POS_LAST      = PosWidth'(HeaderBytes - 1);

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic        data_valid;
    logic        frame_end;
    logic [1:0]  status;
    logic [7:0]  frame_type;
    logic [7:0]  frame_flags;
    logic [15:0] frame_length;
    logic [31:0] frame_id;
    logic [31:0] time_stamp;
  } result_t;

  // reflected crc-32, one byte per call, unrolls to an xor network
  function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CrcPoly;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

>>> rtl/core/crc_checked_frame_receiver_unit.sv
// Frame receiver with CRC-32 check on a byte stream.
// Input channel: rx_byte with in_valid / in_stall, one stream byte per word.
// Output channel: out_valid / out_stall with one word per payload byte and one
// word for the end of a zero-length or over-limit frame; header bytes give none.
// The last payload word of a frame has frame_end set with status and header fields.
// Configuration: cfg_wr_en / cfg_wr_data write max_payload_length at once; the user
// must write it only while the block is idle, as the block does not enforce this.
// The limit is sampled at the last header byte; a result is registered and
// appears in the cycle after its byte is accepted. Throughput: one byte per cycle
// while in_stall is low; the crc update is one xor network per byte between the
// input handshake and the output register. in_stall rises only while a result is
// held and out_stall is high; a held result is taken and replaced in the same cycle.
// Reset (rst, synchronous): header phase, crc all ones, limit 1024, output empty.
// A frame longer than the limit reports status 2 and then every later byte is
// swallowed without a result until reset.
module crc_checked_frame_receiver_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  payload_byte,
  output logic        data_valid,
  output logic        frame_end,
  output logic [1:0]  status,
  output logic [7:0]  frame_type,
  output logic [7:0]  frame_flags,
  output logic [15:0] frame_length,
  output logic [31:0] frame_id,
  output logic [31:0] time_stamp
);

  logic [15:0] max_len;
  logic [1:0]  phase, phase_next;
  logic [crc_frx_pkg::PosWidth-1:0] hdr_pos, hdr_pos_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic [7:0]  held_type, held_type_next;
  logic [7:0]  held_flags, held_flags_next;
  logic [15:0] held_length, held_length_next;
  logic [31:0] held_id, held_id_next;
  logic [31:0] held_stamp, held_stamp_next;
  logic [31:0] expected_crc, expected_crc_next;
  logic [31:0] running_crc, running_crc_next;
  logic [31:0] crc_upd;

  crc_frx_pkg::result_t res, res_next;
  logic res_valid_next;
  logic take;

  assign in_stall = out_valid & out_stall;
  assign take     = in_valid & ~in_stall;
  assign crc_upd  = crc_frx_pkg::crc_byte(running_crc, rx_byte);

  always_comb begin
    phase_next        = phase;
    hdr_pos_next      = hdr_pos;
    bytes_left_next   = bytes_left;
    held_type_next    = held_type;
    held_flags_next   = held_flags;
    held_length_next  = held_length;
    held_id_next      = held_id;
    held_stamp_next   = held_stamp;
    expected_crc_next = expected_crc;
    running_crc_next  = running_crc;
    res_next          = '0;
    res_valid_next    = 1'b0;

    case (phase)
      crc_frx_pkg::PHASE_HEADER: begin
        if (hdr_pos == crc_frx_pkg::POS_TYPE) begin
          held_type_next = rx_byte;
        end else if (hdr_pos == crc_frx_pkg::POS_FLAGS) begin
          held_flags_next = rx_byte;
        end else if (hdr_pos == crc_frx_pkg::POS_LEN_HI
                     || hdr_pos == crc_frx_pkg::POS_LEN_LO) begin
          held_length_next = {held_length[7:0], rx_byte};
        end else if (hdr_pos >= crc_frx_pkg::POS_ID_FIRST
                     && hdr_pos <= crc_frx_pkg::POS_ID_LAST) begin
          held_id_next = {held_id[23:0], rx_byte};
        end else if (hdr_pos >= crc_frx_pkg::POS_TS_FIRST
                     && hdr_pos <= crc_frx_pkg::POS_TS_LAST) begin
          held_stamp_next = {held_stamp[23:0], rx_byte};
        end else if (hdr_pos >= crc_frx_pkg::POS_CRC_FIRST
                     && hdr_pos <= crc_frx_pkg::POS_CRC_LAST) begin
          expected_crc_next = {expected_crc[23:0], rx_byte};
        end

        if (hdr_pos != crc_frx_pkg::POS_LAST) begin
          hdr_pos_next = hdr_pos + 1'b1;
        end else begin
          hdr_pos_next     = '0;
          running_crc_next = crc_frx_pkg::CrcOnes;
          res_next.frame_type   = held_type;
          res_next.frame_flags  = held_flags;
          res_next.frame_length = held_length;
          res_next.frame_id     = held_id;
          res_next.time_stamp   = held_stamp;
          if (held_length > max_len) begin
            phase_next        = crc_frx_pkg::PHASE_HALTED;
            res_next.frame_end = 1'b1;
            res_next.status   = crc_frx_pkg::STATUS_TOO_LONG;
            res_valid_next    = 1'b1;
          end else if (held_length == 16'd0) begin
            res_next.frame_end = 1'b1;
            res_next.status   = (expected_crc == 32'd0) ? crc_frx_pkg::STATUS_OK
                                                        : crc_frx_pkg::STATUS_CRC_BAD;
            res_valid_next    = 1'b1;
          end else begin
            bytes_left_next = held_length;
            phase_next      = crc_frx_pkg::PHASE_PAYLOAD;
            res_next        = '0;
          end
        end
      end
      crc_frx_pkg::PHASE_PAYLOAD: begin
        res_next.payload_byte = rx_byte;
        res_next.data_valid   = 1'b1;
        res_valid_next        = 1'b1;
        running_crc_next      = crc_upd;
        bytes_left_next       = bytes_left - 1'b1;
        if (bytes_left == 16'd1) begin
          res_next.frame_end    = 1'b1;
          res_next.status       = ((crc_upd ^ crc_frx_pkg::CrcOnes) == expected_crc)
                                  ? crc_frx_pkg::STATUS_OK : crc_frx_pkg::STATUS_CRC_BAD;
          res_next.frame_type   = held_type;
          res_next.frame_flags  = held_flags;
          res_next.frame_length = held_length;
          res_next.frame_id     = held_id;
          res_next.time_stamp   = held_stamp;
          phase_next            = crc_frx_pkg::PHASE_HEADER;
          hdr_pos_next          = '0;
          running_crc_next      = crc_frx_pkg::CrcOnes;
        end
      end
      default: begin
        // halted: bytes are swallowed
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len      <= crc_frx_pkg::MaxLenReset;
      phase        <= crc_frx_pkg::PHASE_HEADER;
      hdr_pos      <= '0;
      bytes_left   <= '0;
      held_type    <= '0;
      held_flags   <= '0;
      held_length  <= '0;
      held_id      <= '0;
      held_stamp   <= '0;
      expected_crc <= '0;
      running_crc  <= crc_frx_pkg::CrcOnes;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_len <= cfg_wr_data;
      end
      if (take) begin
        phase        <= phase_next;
        hdr_pos      <= hdr_pos_next;
        bytes_left   <= bytes_left_next;
        held_type    <= held_type_next;
        held_flags   <= held_flags_next;
        held_length  <= held_length_next;
        held_id      <= held_id_next;
        held_stamp   <= held_stamp_next;
        expected_crc <= expected_crc_next;
        running_crc  <= running_crc_next;
        out_valid    <= res_valid_next;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res <= res_next;
    end
  end

  assign payload_byte = res.payload_byte;
  assign data_valid   = res.data_valid;
  assign frame_end    = res.frame_end;
  assign status       = res.status;
  assign frame_type   = res.frame_type;
  assign frame_flags  = res.frame_flags;
  assign frame_length = res.frame_length;
  assign frame_id     = res.frame_id;
  assign time_stamp   = res.time_stamp;

endmodule
